[sv/sal_pkg.sv]
// sal_pkg: shared constants and types for the sorted array list
`default_nettype none
package sal_pkg;

    localparam int DEPTH      = 8;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = 4;
    localparam int STAT_W     = 3;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_READ   = 2'd3
    } req_e_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_e_t;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    // broadcast to every cell
    typedef struct packed {
        logic             ins_en;
        logic             rem_en;
        value_t           value;
        logic [IDX_W-1:0] k;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

    // rippled from cell to cell
    typedef struct packed {
        logic lt;
        logic found;
        logic past_k;
    } cell_chain_t;

endpackage
`default_nettype wire

[sv/sorted_array_list.sv]
// sorted_array_list: sorted list of signed values built as a row of entry cells
// result: each accepted item's result is captured in the output register
// throughput: one item per cycle while results are taken; each request is served
// by all cells comparing and shifting at once
// reset: count and output valid clear; entry contents are left unset
`default_nettype none
module sorted_array_list (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire logic [1:0]                       req_type,
    input  wire logic signed [sal_pkg::VALUE_BITS-1:0] value,
    input  wire logic [sal_pkg::POS_W-1:0]        position,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output logic [sal_pkg::STAT_W-1:0]            status,
    output logic signed [sal_pkg::VALUE_BITS-1:0] result_value,
    output logic [sal_pkg::POS_W-1:0]             result_position,
    output logic [sal_pkg::CNT_W-1:0]             entry_count
);

    localparam int N = sal_pkg::DEPTH;

    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    sal_pkg::status_e_t             status_reg;
    sal_pkg::status_e_t             status_next;
    sal_pkg::value_t                rval_reg;
    sal_pkg::value_t                rval_next;
    logic [sal_pkg::POS_W-1:0]      rpos_reg;
    logic [sal_pkg::POS_W-1:0]      rpos_next;
    logic [sal_pkg::CNT_W-1:0]      count_reg;
    logic [sal_pkg::CNT_W-1:0]      count_next;

    logic                           accept;
    logic                           full;
    logic                           empty;
    logic                           pos_ok;
    sal_pkg::req_e_t                req;
    sal_pkg::cell_ctrl_t            ctrl;
    sal_pkg::cell_chain_t           chain [N+1];
    sal_pkg::value_t                ent [N];
    sal_pkg::value_t                rd_ent [N];
    logic [N-1:0]                   ins_here_vec;
    logic [N-1:0]                   first_eq_vec;
    sal_pkg::value_t                rd_value;
    logic [sal_pkg::POS_W-1:0]      ins_pos;
    logic [sal_pkg::POS_W-1:0]      found_pos;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign req       = sal_pkg::req_e_t'(req_type);
    assign full      = count_reg == sal_pkg::CNT_W'(N);
    assign empty     = count_reg == '0;
    assign pos_ok    = (position != '0)
                       && (position <= sal_pkg::POS_W'(count_reg));

    assign ctrl.ins_en = accept && (req == sal_pkg::REQ_INSERT) && !full;
    assign ctrl.rem_en = accept && (req == sal_pkg::REQ_REMOVE) && !empty && pos_ok;
    assign ctrl.value  = value;
    assign ctrl.k      = sal_pkg::IDX_W'(position - sal_pkg::POS_W'(1));
    assign ctrl.count  = count_reg;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            sal_pkg::value_t left_e;
            sal_pkg::value_t right_e;
            if (g == 0)
            begin : g_first
                assign left_e = '0;
            end
            else
            begin : g_mid_l
                assign left_e = ent[g-1];
            end
            if (g == N - 1)
            begin : g_last
                assign right_e = ent[g];
            end
            else
            begin : g_mid_r
                assign right_e = ent[g+1];
            end
            sal_cell u_cell (
                .clk         (clk),
                .idx         (sal_pkg::IDX_W'(g)),
                .ctrl        (ctrl),
                .chain_in    (chain[g]),
                .left_entry  (left_e),
                .right_entry (right_e),
                .chain_out   (chain[g+1]),
                .entry       (ent[g]),
                .ins_here    (ins_here_vec[g]),
                .first_eq    (first_eq_vec[g]),
                .rd_entry    (rd_ent[g])
            );
        end
    endgenerate

    // one-hot flags from the cells folded to positions and data
    always_comb
    begin
        rd_value  = '0;
        ins_pos   = '0;
        found_pos = '0;
        for (int i = 0; i < N; i++)
        begin
            rd_value = rd_value | rd_ent[i];
            if (ins_here_vec[i])
                ins_pos = ins_pos | sal_pkg::POS_W'(i + 1);
            if (first_eq_vec[i])
                found_pos = found_pos | sal_pkg::POS_W'(i + 1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        rval_next      = rval_reg;
        rpos_next      = rpos_reg;
        count_next     = count_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = sal_pkg::ST_OK;
            rval_next      = '0;
            rpos_next      = '0;
            unique case (req) inside
                sal_pkg::REQ_INSERT:
                begin
                    if (full)
                        status_next = sal_pkg::ST_FULL;
                    else
                    begin
                        rpos_next  = ins_pos;
                        count_next = count_reg + sal_pkg::CNT_W'(1);
                    end
                end
                sal_pkg::REQ_SEARCH:
                begin
                    if (empty)
                        status_next = sal_pkg::ST_EMPTY;
                    else if (chain[N].found)
                        rpos_next = found_pos;
                    else
                        status_next = sal_pkg::ST_NOTFOUND;
                end
                sal_pkg::REQ_REMOVE,
                sal_pkg::REQ_READ:
                begin
                    if (empty)
                        status_next = sal_pkg::ST_EMPTY;
                    else if (!pos_ok)
                        status_next = sal_pkg::ST_BADPOS;
                    else
                    begin
                        rval_next = rd_value;
                        if (req == sal_pkg::REQ_REMOVE)
                            count_next = count_reg - sal_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = sal_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rval_reg   <= rval_next;
        rpos_reg   <= rpos_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign result_value    = rval_reg;
    assign result_position = rpos_reg;
    assign entry_count     = count_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sal_pkg::CNT_W'(N))
        else $error("entry count above depth");

    a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |-> $onehot(ins_here_vec))
        else $error("insert slot not unique");

    a_first_eq: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_eq_vec))
        else $error("several first matches");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without an item");
`endif

endmodule
`default_nettype wire

[sv/sal_cell.sv]
// sal_cell: one list entry with its compare, insert and remove shift logic
`default_nettype none
module sal_cell (
    input  wire logic                      clk,
    input  wire logic [sal_pkg::IDX_W-1:0] idx,
    input  wire sal_pkg::cell_ctrl_t       ctrl,
    input  wire sal_pkg::cell_chain_t      chain_in,
    input  wire sal_pkg::value_t           left_entry,
    input  wire sal_pkg::value_t           right_entry,
    output sal_pkg::cell_chain_t           chain_out,
    output sal_pkg::value_t                entry,
    output logic                           ins_here,
    output logic                           first_eq,
    output sal_pkg::value_t                rd_entry
);

    sal_pkg::value_t entry_reg;
    sal_pkg::value_t entry_next;
    logic            valid;
    logic            lt;
    logic            eq;
    logic            at_k;
    logic            at_end;

    assign valid  = {1'b0, idx} < ctrl.count;
    assign lt     = valid && (ctrl.value < entry_reg);
    assign eq     = valid && (ctrl.value == entry_reg);
    assign at_k   = idx == ctrl.k;
    assign at_end = {1'b0, idx} == ctrl.count;

    assign ins_here         = (lt || at_end) && !chain_in.lt;
    assign first_eq         = eq && !chain_in.found;
    assign chain_out.lt     = lt;
    assign chain_out.found  = chain_in.found | eq;
    assign chain_out.past_k = chain_in.past_k | at_k;
    assign entry            = entry_reg;
    assign rd_entry         = at_k ? entry_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (chain_in.lt)
                entry_next = left_entry;
            else if (ins_here)
                entry_next = ctrl.value;
        end
        else if (ctrl.rem_en && chain_out.past_k)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire
